/* rtl/core/hktr_pkg.sv */
package hktr_pkg;

    localparam int unsigned TIME_UNIT_MS = 10;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned UNITS_W = 8;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] MULTI_KEYS = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] ONE_KEY    = COUNT_W'(1);

    localparam logic [UNITS_W-1:0] DELAY_RESET  = UNITS_W'(20);
    localparam logic [UNITS_W-1:0] REPEAT_RESET = UNITS_W'(5);

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_DELAY  = 2'd1,
        REG_REPEAT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic               enable;
        logic [UNITS_W-1:0] delay_units;
        logic [UNITS_W-1:0] repeat_units;
        logic               clear_track;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] held_count;
        logic [TIME_W-1:0]  now_ms;
    } in_item_t;

    typedef struct packed {
        logic              repeating;
        logic [TIME_W-1:0] beat_total;
        logic              beat;
    } out_item_t;

    // Scale time units to milliseconds.
    function automatic logic [TIME_W-1:0] units_to_ms(input logic [UNITS_W-1:0] units);
        logic [TIME_W-1:0] ms;
        ms = TIME_W'(units) * TIME_W'(TIME_UNIT_MS);
        return ms;
    endfunction

endpackage

/* rtl/core/hktr_cfg.sv */
module hktr_cfg
    import hktr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic               enable_reg;
    logic [UNITS_W-1:0] delay_reg;
    logic [UNITS_W-1:0] repeat_reg;
    logic               clear_reg;
    logic               wr_en;
    reg_idx_t           idx;
    logic [UNITS_W-1:0] wr_units;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;
    assign idx      = reg_idx_t'(paddr[3:2]);
    assign wr_units = pwdata[UNITS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            delay_reg  <= DELAY_RESET;
            repeat_reg <= REPEAT_RESET;
            clear_reg  <= 1'b0;
        end
        else
        begin
            clear_reg <= 1'b0;
            if (wr_en)
            begin
                case (idx)
                    REG_ENABLE:
                    begin
                        enable_reg <= pwdata[0];
                        clear_reg  <= 1'b1;
                    end
                    REG_DELAY:
                    begin
                        // zero writes are dropped
                        if (wr_units != '0)
                            delay_reg <= wr_units;
                    end
                    REG_REPEAT:
                    begin
                        if (wr_units != '0)
                            repeat_reg <= wr_units;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLE: prdata = APB_DATA_W'(enable_reg);
            REG_DELAY:  prdata = APB_DATA_W'(delay_reg);
            REG_REPEAT: prdata = APB_DATA_W'(repeat_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.enable       = enable_reg;
    assign cfg.delay_units  = delay_reg;
    assign cfg.repeat_units = repeat_reg;
    assign cfg.clear_track  = clear_reg;

endmodule

/* rtl/core/held_key_turbo_repeater.sv */
// Turbo repeater for held keys. Each input beat carries a millisecond timestamp
// and the number of keys held; each one yields exactly one output beat with the
// beat flag, the running beat total and the repeating flag. An update is taken
// every clock cycle while the output is not stalled: it passes an input register,
// one step of compare and update logic against the tracked state, and a result
// register. While a result waits for m_axis_tready the input register holds one
// more update, and s_axis_tready then stays low until the result is taken.
// Registers sit on the APB port at 0x0 (enable; any write clears the tracked count
// and the running flag), 0x4 (delay_units) and 0x8 (repeat_units); writes of zero
// to the two timing registers are ignored. Write registers only while no update is
// in flight.
module held_key_turbo_repeater
    import hktr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] now_ms, [39:32] held_count
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] beat, [32:1] beat_total,
                                                   // [33] repeating, [39:34] zero
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t cfg;

    hktr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic      in_accept;
    logic      advance;

    // Tracked state
    logic [COUNT_W-1:0] tracked_reg, tracked_next;
    logic [COUNT_W-1:0] interval_count_reg, interval_count_next;
    logic [TIME_W-1:0]  change_time_reg, change_time_next;
    logic [TIME_W-1:0]  last_beat_reg, last_beat_next;
    logic               running_reg, running_next;
    logic [TIME_W-1:0]  beat_count_reg, beat_count_next;

    logic [TIME_W-1:0]  delay_ms;
    logic [TIME_W-1:0]  repeat_ms;
    logic               changed;
    logic [COUNT_W-1:0] count_mid;
    logic [TIME_W-1:0]  change_mid;
    logic [TIME_W-1:0]  hold_elapsed;
    logic [TIME_W-1:0]  beat_elapsed;
    logic               start;
    logic               stop;
    logic               interval;
    logic               beat_fire;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign delay_ms  = units_to_ms(cfg.delay_units);
    assign repeat_ms = units_to_ms(cfg.repeat_units);

    always_comb
    begin
        changed      = in_data_reg.held_count != tracked_reg;
        count_mid    = in_data_reg.held_count;
        change_mid   = changed ? in_data_reg.now_ms : change_time_reg;
        hold_elapsed = in_data_reg.now_ms - change_mid;
        beat_elapsed = in_data_reg.now_ms - last_beat_reg;

        start = ~running_reg & (count_mid >= MULTI_KEYS) & (hold_elapsed >= delay_ms);
        stop  = running_reg & (count_mid == '0);
        // On start the interval restarts at now, so no beat in the same update.
        interval  = running_reg & ~stop & (beat_elapsed >= repeat_ms);
        beat_fire = interval & ((count_mid >= MULTI_KEYS) |
                    ((count_mid == ONE_KEY) & (interval_count_reg >= MULTI_KEYS)));

        tracked_next        = tracked_reg;
        interval_count_next = interval_count_reg;
        change_time_next    = change_time_reg;
        last_beat_next      = last_beat_reg;
        running_next        = running_reg;
        beat_count_next     = beat_count_reg;
        out_data_next.beat  = 1'b0;

        if (cfg.enable)
        begin
            tracked_next     = count_mid;
            change_time_next = change_mid;
            if (start)
            begin
                running_next   = 1'b1;
                last_beat_next = in_data_reg.now_ms;
            end
            else if (stop)
            begin
                running_next = 1'b0;
            end
            if (interval)
            begin
                last_beat_next      = in_data_reg.now_ms;
                interval_count_next = count_mid;
            end
            if (beat_fire)
            begin
                beat_count_next    = beat_count_reg + TIME_W'(1);
                out_data_next.beat = 1'b1;
            end
        end

        out_data_next.beat_total = beat_count_next;
        out_data_next.repeating  = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            tracked_reg        <= '0;
            interval_count_reg <= '0;
            change_time_reg    <= '0;
            last_beat_reg      <= '0;
            running_reg        <= 1'b0;
            beat_count_reg     <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg.clear_track)
            begin
                tracked_reg        <= '0;
                interval_count_reg <= '0;
                running_reg        <= 1'b0;
            end
            else if (advance)
            begin
                tracked_reg        <= tracked_next;
                interval_count_reg <= interval_count_next;
                change_time_reg    <= change_time_next;
                last_beat_reg      <= last_beat_next;
                running_reg        <= running_next;
                beat_count_reg     <= beat_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg.now_ms     <= s_axis_tdata[TIME_W-1:0];
            in_data_reg.held_count <= s_axis_tdata[TIME_W +: COUNT_W];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

/* rtl/core/hktr_checker.sv */
module hktr_checker
    import hktr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   pready
);

    logic              out_accept;
    logic [TIME_W-1:0] prev_total_reg;

    assign out_accept = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_total_reg <= '0;
        else if (out_accept)
            prev_total_reg <= m_axis_tdata[TIME_W:1];
    end

    // Total advances by exactly the beat flag from one result to the next.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept |-> m_axis_tdata[TIME_W:1] == prev_total_reg + TIME_W'(m_axis_tdata[0]))
        else $error("beat_total does not follow the beat flags");

    a_beat_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[TIME_W+1])
        else $error("beat shown while not repeating");

    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");

endmodule

bind held_key_turbo_repeater hktr_checker u_hktr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
